// File: rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// expression that must never be true at a rising clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`endif

// File: rtl/mcpid_pkg.sv
// ----------------------------------------------------------------------------
// mcpid_pkg
// Shared types, codes and constants of the multi-channel PID controller.
// ----------------------------------------------------------------------------
package mcpid_pkg;

  // time step clamp and fixed-point one
  localparam logic [15:0] DT_MIN  = 16'd33;
  localparam logic [15:0] DT_MAX  = 16'd6554;
  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  // configuration register indexes
  localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [2:0] REG_DERIV_GAIN  = 3'd2;
  localparam logic [2:0] REG_INTEG_LIMIT = 3'd3;
  localparam logic [2:0] REG_OUT_LOW     = 3'd4;
  localparam logic [2:0] REG_OUT_HIGH    = 3'd5;
  localparam logic [2:0] REG_DERIV_ALPHA = 3'd6;
  localparam logic [2:0] REG_SLEW_LIMIT  = 3'd7;

  // datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_ID,
    OP_INTEG,
    OP_ACC0,
    OP_SUM0,
    OP_SUM1,
    OP_MUL_RH,
    OP_ACC1,
    OP_ACC2,
    OP_DERIV,
    OP_MUL_D,
    OP_SUM2,
    OP_LIMIT,
    OP_FINISH,
    OP_CLEAR,
    OP_BADCH,
    OP_EOVF
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic accept;
    logic clr;
    logic bad;
    logic eovf;
    logic div_done;
    logic out_empty;
  } status_t;

  // counter increment that stops at all ones
  function automatic logic [31:0] sat_inc(input logic [31:0] v, input logic [1:0] n);
    logic [33:0] s;
    s = {2'b00, v} + {32'd0, n};
    return (s > {2'b00, CNT_MAX}) ? CNT_MAX : s[31:0];
  endfunction

endpackage

// File: rtl/mcpid_div.sv
// ----------------------------------------------------------------------------
// mcpid_div
// Serial restoring divider: (diff * 2^16) / dt, truncated toward zero.
// ----------------------------------------------------------------------------
module mcpid_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [33:0] diff_i,
  input  logic        [12:0] dt_i,
  output logic signed [49:0] quo_o,
  output logic               done_o
);
  import mcpid_pkg::*;

  localparam int unsigned NBITS = 50;

  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic        neg_q, neg_d;
  logic [49:0] sh_q, sh_d;
  logic [12:0] rem_q, rem_d;
  logic [12:0] dv_q, dv_d;
  logic [33:0] mag;
  logic [13:0] r2;
  logic        fit;

  assign mag = diff_i[33] ? 34'(-diff_i) : 34'(diff_i);
  assign r2  = {rem_q, sh_q[49]};
  assign fit = r2 >= {1'b0, dv_q};

  // one quotient bit per cycle
  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    neg_d  = neg_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    dv_d   = dv_q;
    if (start_i) begin
      cnt_d  = '0;
      busy_d = 1'b1;
      done_d = 1'b0;
      neg_d  = diff_i[33];
      sh_d   = {mag, 16'd0};
      rem_d  = '0;
      dv_d   = dt_i;
    end else if (busy_q) begin
      rem_d = fit ? 13'(r2 - {1'b0, dv_q}) : r2[12:0];
      sh_d  = {sh_q[48:0], fit};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(NBITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    sh_q  <= sh_d;
    rem_q <= rem_d;
    dv_q  <= dv_d;
  end

  assign quo_o  = neg_q ? -$signed(sh_q) : $signed(sh_q);
  assign done_o = done_q;

endmodule

// File: rtl/mcpid_dp.sv
// ----------------------------------------------------------------------------
// mcpid_dp
// Datapath: configuration, channel state, shared multiplier, output register.
// ----------------------------------------------------------------------------
module mcpid_dp #(
  parameter int CHANNELS = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mcpid_pkg::cmd_t       cmd_i,
  output mcpid_pkg::status_t    status_o,
  input  logic                  in_ready_i,
  input  logic                  s_axis_tvalid,
  input  logic [79:0]           s_axis_tdata,
  input  logic [3:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [135:0]          m_axis_tdata,
  output logic [2:0]            m_axis_tuser,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [31:0]           cfg_data_i
);
  import mcpid_pkg::*;

  localparam int IDXW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // configuration registers
  logic signed [31:0] gp_q, gi_q, gd_q, ol_q, oh_q;
  logic        [30:0] lim_q, slew_q;
  logic        [16:0] alpha_q;

  // input item
  logic [2:0]         ch_q;
  logic signed [31:0] tgt_q, meas_q;
  logic [12:0]        dt_q;
  logic               clr_q;

  // channel state
  logic signed [31:0] integ_mem [CHANNELS];
  logic signed [31:0] last_mem  [CHANNELS];
  logic signed [31:0] sm_mem    [CHANNELS];
  logic signed [31:0] held_mem  [CHANNELS];
  logic        [31:0] satc_mem  [CHANNELS];
  logic        [31:0] clpc_mem  [CHANNELS];
  logic        [31:0] fltc_mem  [CHANNELS];

  // working registers
  logic signed [31:0] w_integ, w_last, w_sm, w_held;
  logic        [31:0] w_satc, w_clpc, w_fltc;
  logic signed [32:0] err_q;
  logic               eovf_q;
  logic signed [31:0] integ_q, deriv_q;
  logic               clamped_q, flt_q;
  logic signed [65:0] p_q, acc_q;
  logic signed [49:0] sum_q;
  logic signed [33:0] lim_out_q;

  // output register
  logic               o_valid_q;
  logic [2:0]         o_ch_q;
  logic [31:0]        o_cmd_q, o_sc_q, o_cc_q, o_fc_q;
  logic               o_ic_q, o_sat_q, o_flt_q;

  logic               accept, bad;
  logic [IDXW-1:0]    idx;
  logic [15:0]        ts;
  logic [12:0]        dt_cl;
  logic signed [32:0] err_w;
  logic [16:0]        alpha_eff, one_minus;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] psh, dsh;
  logic signed [34:0] isum, lim35;
  logic signed [33:0] held34, step34, lo34, hi34, s1, v1, oh34, ol34;
  logic               sovf, hi_hit, lo_hit;
  logic               div_start, div_done;
  logic signed [33:0] div_diff;
  logic signed [49:0] quo;

  assign accept    = s_axis_tvalid & in_ready_i;
  assign bad       = int'(ch_q) >= CHANNELS;
  assign idx       = bad ? '0 : IDXW'(ch_q);
  assign ts        = s_axis_tdata[79:64];
  assign dt_cl     = (ts < DT_MIN) ? DT_MIN[12:0] : (ts > DT_MAX) ? DT_MAX[12:0] : ts[12:0];
  assign err_w     = 33'(tgt_q) - 33'(meas_q);
  assign alpha_eff = (alpha_q > ONE_Q16) ? ONE_Q16 : alpha_q;
  assign one_minus = ONE_Q16 - alpha_eff;
  assign psh       = p_q >>> 16;
  assign dsh       = acc_q >>> 16;
  assign lim35     = $signed({4'd0, lim_q});
  assign isum      = $signed({{3{w_integ[31]}}, w_integ}) + $signed(psh[34:0]);
  assign held34    = 34'(w_held);
  assign step34    = $signed(psh[33:0]);
  assign lo34      = held34 - step34;
  assign hi34      = held34 + step34;
  assign sovf      = !((&sum_q[49:31]) || (~|sum_q[49:31]));
  assign s1        = sovf ? held34 : 34'(signed'(sum_q[31:0]));
  assign oh34      = 34'(oh_q);
  assign ol34      = 34'(ol_q);
  assign hi_hit    = lim_out_q > oh34;
  assign v1        = hi_hit ? oh34 : lim_out_q;
  assign lo_hit    = v1 < ol34;
  assign div_start = cmd_i.op == OP_MUL_ID;
  assign div_diff  = 34'(err_q) - 34'(w_last);

  mcpid_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .diff_i  (div_diff),
    .dt_i    (dt_q),
    .quo_o   (quo),
    .done_o  (div_done)
  );

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_MUL_ID: begin mul_a = err_q;   mul_b = {20'd0, dt_q};      end
      OP_INTEG:  begin mul_a = 33'(w_sm); mul_b = {16'd0, one_minus}; end
      OP_ACC0:   begin mul_a = 33'(gp_q); mul_b = err_q;            end
      OP_SUM0:   begin mul_a = 33'(gi_q); mul_b = 33'(integ_q);     end
      OP_MUL_RH: begin mul_a = quo[49:17]; mul_b = {16'd0, alpha_eff}; end
      OP_ACC1:   begin mul_a = {16'd0, quo[16:0]}; mul_b = {16'd0, alpha_eff}; end
      OP_MUL_D:  begin mul_a = 33'(gd_q); mul_b = 33'(deriv_q);     end
      OP_SUM2:   begin mul_a = {2'd0, slew_q}; mul_b = {20'd0, dt_q}; end
      default:   ;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gp_q    <= 32'sd65536;
      gi_q    <= 32'sd655;
      gd_q    <= 32'sd328;
      lim_q   <= 31'd1966080;
      ol_q    <= -32'sd6553600;
      oh_q    <= 32'sd6553600;
      alpha_q <= 17'd16384;
      slew_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PROP_GAIN:   gp_q    <= cfg_data_i;
        REG_INTEG_GAIN:  gi_q    <= cfg_data_i;
        REG_DERIV_GAIN:  gd_q    <= cfg_data_i;
        REG_INTEG_LIMIT: lim_q   <= cfg_data_i[30:0];
        REG_OUT_LOW:     ol_q    <= cfg_data_i;
        REG_OUT_HIGH:    oh_q    <= cfg_data_i;
        REG_DERIV_ALPHA: alpha_q <= cfg_data_i[16:0];
        REG_SLEW_LIMIT:  slew_q  <= cfg_data_i[30:0];
        default:         ;
      endcase
    end
  end

  // channel state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        integ_mem[i] <= '0;
        last_mem[i]  <= '0;
        sm_mem[i]    <= '0;
        held_mem[i]  <= '0;
        satc_mem[i]  <= '0;
        clpc_mem[i]  <= '0;
        fltc_mem[i]  <= '0;
      end
      o_valid_q <= 1'b0;
    end else begin
      if (o_valid_q && m_axis_tready) begin
        o_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_CLEAR: begin
          for (int i = 0; i < CHANNELS; i++) begin
            integ_mem[i] <= '0;
            last_mem[i]  <= '0;
            sm_mem[i]    <= '0;
            held_mem[i]  <= '0;
            satc_mem[i]  <= '0;
            clpc_mem[i]  <= '0;
            fltc_mem[i]  <= '0;
          end
          o_valid_q <= 1'b1;
        end
        OP_BADCH: o_valid_q <= 1'b1;
        OP_EOVF: begin
          fltc_mem[idx] <= sat_inc(w_fltc, 2'd1);
          o_valid_q     <= 1'b1;
        end
        OP_FINISH: begin
          integ_mem[idx] <= integ_q;
          last_mem[idx]  <= err_q[31:0];
          sm_mem[idx]    <= deriv_q;
          held_mem[idx]  <= lo_hit ? ol_q : v1[31:0];
          satc_mem[idx]  <= sat_inc(w_satc, {1'b0, hi_hit} + {1'b0, lo_hit});
          clpc_mem[idx]  <= sat_inc(w_clpc, {1'b0, clamped_q});
          fltc_mem[idx]  <= sat_inc(w_fltc, {1'b0, flt_q});
          o_valid_q      <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // working registers and result payload
  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
    if (accept) begin
      ch_q   <= s_axis_tuser[2:0];
      clr_q  <= s_axis_tuser[3];
      tgt_q  <= s_axis_tdata[31:0];
      meas_q <= s_axis_tdata[63:32];
      dt_q   <= dt_cl;
    end
    case (cmd_i.op)
      OP_LOAD: begin
        w_integ <= integ_mem[idx];
        w_last  <= last_mem[idx];
        w_sm    <= sm_mem[idx];
        w_held  <= held_mem[idx];
        w_satc  <= satc_mem[idx];
        w_clpc  <= clpc_mem[idx];
        w_fltc  <= fltc_mem[idx];
        err_q   <= err_w;
        eovf_q  <= err_w[32] != err_w[31];
      end
      OP_INTEG: begin
        if (isum > lim35) begin
          integ_q   <= lim35[31:0];
          clamped_q <= 1'b1;
        end else if (isum < -lim35) begin
          integ_q   <= 32'(-lim35);
          clamped_q <= 1'b1;
        end else begin
          integ_q   <= isum[31:0];
          clamped_q <= 1'b0;
        end
      end
      OP_ACC0: acc_q <= p_q;
      OP_SUM0: sum_q <= psh[49:0];
      OP_SUM1: sum_q <= sum_q + psh[49:0];
      OP_ACC1: acc_q <= acc_q + (p_q <<< 17);
      OP_ACC2: acc_q <= acc_q + p_q;
      OP_DERIV: begin
        if ((&dsh[65:31]) || (~|dsh[65:31])) begin
          deriv_q <= dsh[31:0];
        end else begin
          deriv_q <= dsh[65] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
      end
      OP_SUM2: sum_q <= sum_q + psh[49:0];
      OP_LIMIT: begin
        flt_q <= sovf;
        if (slew_q != '0 && s1 < lo34) begin
          lim_out_q <= lo34;
        end else if (slew_q != '0 && s1 > hi34) begin
          lim_out_q <= hi34;
        end else begin
          lim_out_q <= s1;
        end
      end
      OP_CLEAR, OP_BADCH: begin
        o_ch_q  <= ch_q;
        o_cmd_q <= '0;
        o_ic_q  <= 1'b0;
        o_sat_q <= 1'b0;
        o_flt_q <= cmd_i.op == OP_BADCH;
        o_sc_q  <= '0;
        o_cc_q  <= '0;
        o_fc_q  <= '0;
      end
      OP_EOVF: begin
        o_ch_q  <= ch_q;
        o_cmd_q <= w_held;
        o_ic_q  <= 1'b0;
        o_sat_q <= 1'b0;
        o_flt_q <= 1'b1;
        o_sc_q  <= w_satc;
        o_cc_q  <= w_clpc;
        o_fc_q  <= sat_inc(w_fltc, 2'd1);
      end
      OP_FINISH: begin
        o_ch_q  <= ch_q;
        o_cmd_q <= lo_hit ? ol_q : v1[31:0];
        o_ic_q  <= clamped_q;
        o_sat_q <= hi_hit | lo_hit;
        o_flt_q <= flt_q;
        o_sc_q  <= sat_inc(w_satc, {1'b0, hi_hit} + {1'b0, lo_hit});
        o_cc_q  <= sat_inc(w_clpc, {1'b0, clamped_q});
        o_fc_q  <= sat_inc(w_fltc, {1'b0, flt_q});
      end
      default: ;
    endcase
  end

  assign status_o.accept    = accept;
  assign status_o.clr       = clr_q;
  assign status_o.bad       = bad;
  assign status_o.eovf      = eovf_q;
  assign status_o.div_done  = div_done;
  assign status_o.out_empty = !o_valid_q;

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tuser  = o_ch_q;
  assign m_axis_tdata  = {5'd0, o_fc_q, o_cc_q, o_sc_q, o_flt_q, o_sat_q, o_ic_q, o_cmd_q};

endmodule

// File: rtl/mcpid_ctrl.sv
// ----------------------------------------------------------------------------
// mcpid_ctrl
// Sequencer that steps the datapath through one channel update.
// ----------------------------------------------------------------------------
module mcpid_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mcpid_pkg::status_t status_i,
  output mcpid_pkg::cmd_t    cmd_o,
  output logic               in_ready_o
);
  import mcpid_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LOAD, ST_DISP, ST_MUL_ID, ST_INTEG, ST_ACC0, ST_SUM0, ST_SUM1,
    ST_DWAIT, ST_MUL_RH, ST_ACC1, ST_ACC2, ST_DERIV, ST_MUL_D, ST_SUM2,
    ST_LIMIT, ST_OWAIT, ST_FINISH, ST_SWAIT, ST_SPECIAL
  } state_e;

  state_e state_q, state_d;
  logic   ready_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (status_i.accept) state_d = ST_LOAD;
      ST_LOAD:    state_d = ST_DISP;
      ST_DISP: begin
        if (status_i.clr || status_i.bad || status_i.eovf) state_d = ST_SWAIT;
        else state_d = ST_MUL_ID;
      end
      ST_MUL_ID:  state_d = ST_INTEG;
      ST_INTEG:   state_d = ST_ACC0;
      ST_ACC0:    state_d = ST_SUM0;
      ST_SUM0:    state_d = ST_SUM1;
      ST_SUM1:    state_d = ST_DWAIT;
      ST_DWAIT:   if (status_i.div_done) state_d = ST_MUL_RH;
      ST_MUL_RH:  state_d = ST_ACC1;
      ST_ACC1:    state_d = ST_ACC2;
      ST_ACC2:    state_d = ST_DERIV;
      ST_DERIV:   state_d = ST_MUL_D;
      ST_MUL_D:   state_d = ST_SUM2;
      ST_SUM2:    state_d = ST_LIMIT;
      ST_LIMIT:   state_d = ST_OWAIT;
      ST_OWAIT:   if (status_i.out_empty) state_d = ST_FINISH;
      ST_FINISH:  state_d = ST_IDLE;
      ST_SWAIT:   if (status_i.out_empty) state_d = ST_SPECIAL;
      ST_SPECIAL: state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // state and input ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b1;
    end else begin
      state_q <= state_d;
      ready_q <= state_d == ST_IDLE;
    end
  end

  // datapath command for the current step
  always_comb begin
    cmd_o.op = OP_NONE;
    case (state_q)
      ST_LOAD:   cmd_o.op = OP_LOAD;
      ST_MUL_ID: cmd_o.op = OP_MUL_ID;
      ST_INTEG:  cmd_o.op = OP_INTEG;
      ST_ACC0:   cmd_o.op = OP_ACC0;
      ST_SUM0:   cmd_o.op = OP_SUM0;
      ST_SUM1:   cmd_o.op = OP_SUM1;
      ST_MUL_RH: cmd_o.op = OP_MUL_RH;
      ST_ACC1:   cmd_o.op = OP_ACC1;
      ST_ACC2:   cmd_o.op = OP_ACC2;
      ST_DERIV:  cmd_o.op = OP_DERIV;
      ST_MUL_D:  cmd_o.op = OP_MUL_D;
      ST_SUM2:   cmd_o.op = OP_SUM2;
      ST_LIMIT:  cmd_o.op = OP_LIMIT;
      ST_FINISH: cmd_o.op = OP_FINISH;
      ST_SPECIAL: begin
        if (status_i.clr) cmd_o.op = OP_CLEAR;
        else if (status_i.bad) cmd_o.op = OP_BADCH;
        else cmd_o.op = OP_EOVF;
      end
      default:   cmd_o.op = OP_NONE;
    endcase
  end

  assign in_ready_o = ready_q;

endmodule

// File: rtl/multi_channel_pid_controller_top.sv
// Normal step: the sequencer runs the datapath states in order and waits for
// the 50-step serial divider that forms the raw derivative; clear,
// invalid-channel and error-overflow items skip the arithmetic states.
// Flow control: one item at a time; input ready rises at the same edge that
// loads the result into the output register, which waits while it is full.
// Reset: asynchronous, clears all channel state and restores register defaults.
// ----------------------------------------------------------------------------
// multi_channel_pid_controller_top
// PID controller over several joint channels with shared gains.
// ----------------------------------------------------------------------------
module multi_channel_pid_controller_top #(
  parameter int CHANNELS = 6
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [79:0]  s_axis_tdata,   // target, measured, time_step
  input  logic [3:0]   s_axis_tuser,   // channel, clear_all
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata,   // command, integ_clamped, saturated, fault,
                                       // sat_count, clamp_count, fault_count
  output logic [2:0]   m_axis_tuser,   // channel_out
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);
  import mcpid_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  mcpid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_ready_o (in_ready)
  );

  mcpid_dp #(.CHANNELS(CHANNELS)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .in_ready_i    (in_ready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  assign s_axis_tready = in_ready;

endmodule

// File: rtl/mcpid_chk.sv
// ----------------------------------------------------------------------------
// mcpid_chk
// Port-level checks of the PID controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mcpid_chk #(
  parameter int CHANNELS = 6
) (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [79:0]  s_axis_tdata,
  input logic [3:0]   s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [135:0] m_axis_tdata,
  input logic [2:0]   m_axis_tuser,
  input logic         cfg_we_i,
  input logic [2:0]   cfg_idx_i,
  input logic [31:0]  cfg_data_i
);

  // result held until taken
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)

  // one item in flight: ready drops after every input transfer
  `ASSERT_CLK(a_one_item, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)

  // a saturation flag always comes with a nonzero saturation count
  `ASSERT_NEVER(a_sat_cnt, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[33] && m_axis_tdata[66:35] == 32'd0)

  // an invalid channel (stepped or cleared) gives a zero command, zero counts and all flags zero but fault
  `ASSERT_CLK(a_bad_ch, clk_i, rst_ni, m_axis_tvalid && int'(m_axis_tuser) >= CHANNELS |-> {m_axis_tdata[130:35], m_axis_tdata[33:0]} == 130'd0)

endmodule

bind multi_channel_pid_controller_top mcpid_chk #(.CHANNELS(CHANNELS)) u_mcpid_chk (.*);

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the multi-channel PID controller: every item is fed to
// a local fixed-point model of the controller, and each result is compared
// as a whole with the oldest predicted result, in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mcpid_pkg::*;

  localparam int NCH       = 6;
  localparam int LIMIT_CYC = 1500000;

  typedef struct packed {
    logic [2:0]  chan;
    logic [31:0] command;
    logic        clamped;
    logic        sat;
    logic        fault;
    logic [31:0] sat_cnt;
    logic [31:0] clamp_cnt;
    logic [31:0] fault_cnt;
  } pid_result_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [79:0]  s_axis_tdata;   // target, measured, time_step
  logic [3:0]   s_axis_tuser;   // channel, clear_all
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [135:0] m_axis_tdata;   // command, integ_clamped, saturated, fault,
                                // sat_count, clamp_count, fault_count
  logic [2:0]   m_axis_tuser;   // channel_out
  logic         cfg_we_i;
  logic [2:0]   cfg_idx_i;
  logic [31:0]  cfg_data_i;

  multi_channel_pid_controller_top #(.CHANNELS(NCH)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  // shadow of the configuration registers
  logic signed [31:0] kp, ki, kd, lo_bound, hi_bound;
  logic [30:0]        ilimit, slew;
  logic [16:0]        alpha_reg;

  // shadow of the per-channel state
  logic signed [31:0] integ_st [NCH];
  logic signed [31:0] lasterr_st [NCH];
  logic signed [31:0] dfilt_st [NCH];
  logic signed [31:0] held_st [NCH];
  logic [31:0]        satev [NCH];
  logic [31:0]        clampev [NCH];
  logic [31:0]        faultev [NCH];

  pid_result_t expected_q[$];
  int          mismatches;
  int          cycles;
  int          send_idle_pct;
  int          recv_stall_pct;

  // clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [31:0] bump(input logic [31:0] v);
    return (v == CNT_MAX) ? v : v + 32'd1;
  endfunction

  // arithmetic shift on 128 bits rounds toward minus infinity
  function automatic logic signed [127:0] fl16(input logic signed [127:0] x);
    return x >>> 16;
  endfunction

  function automatic void reset_channels();
    for (int i = 0; i < NCH; i++) begin
      integ_st[i] = 0; lasterr_st[i] = 0; dfilt_st[i] = 0; held_st[i] = 0;
      satev[i] = 0; clampev[i] = 0; faultev[i] = 0;
    end
  endfunction

  // predict the result of one item and advance the channel state
  function automatic pid_result_t pid_predict(input logic [2:0] ch,
      input logic signed [31:0] tgt, input logic signed [31:0] meas,
      input logic [15:0] tstep, input logic clr);
    pid_result_t r;
    logic signed [127:0] err, dt, alf, integ, lim, raw, der, sum, held, stp;
    int c;
    r = '0;
    r.chan = ch;
    if (clr) begin
      reset_channels();
      return r;
    end
    if (ch >= NCH) begin
      r.fault = 1'b1;
      return r;
    end
    c = int'(ch);
    dt = 128'(tstep);
    if (dt < 128'(DT_MIN)) dt = 128'(DT_MIN);
    if (dt > 128'(DT_MAX)) dt = 128'(DT_MAX);
    alf = 128'((alpha_reg > ONE_Q16) ? ONE_Q16 : alpha_reg);
    held = 128'(held_st[c]);
    err = 128'(tgt) - 128'(meas);
    if (err > 128'sd2147483647 || err < -128'sd2147483648) begin
      faultev[c] = bump(faultev[c]);
      r.command = held[31:0];
      r.fault = 1'b1;
      r.sat_cnt = satev[c]; r.clamp_cnt = clampev[c]; r.fault_cnt = faultev[c];
      return r;
    end
    lim = 128'(ilimit);
    integ = 128'(integ_st[c]) + fl16(err * dt);
    if (integ > lim) begin integ = lim; r.clamped = 1'b1; end
    if (integ < -lim) begin integ = -lim; r.clamped = 1'b1; end
    if (r.clamped) clampev[c] = bump(clampev[c]);
    integ_st[c] = integ[31:0];
    // signed division truncates toward zero
    raw = ((err - 128'(lasterr_st[c])) * 128'sd65536) / dt;
    der = fl16(128'(dfilt_st[c]) * (128'sd65536 - alf) + raw * alf);
    if (der > 128'sd2147483647) der = 128'sd2147483647;
    if (der < -128'sd2147483648) der = -128'sd2147483648;
    dfilt_st[c] = der[31:0];
    lasterr_st[c] = err[31:0];
    sum = fl16(128'(kp) * err) + fl16(128'(ki) * integ) + fl16(128'(kd) * der);
    if (sum > 128'sd2147483647 || sum < -128'sd2147483648) begin
      faultev[c] = bump(faultev[c]);
      r.fault = 1'b1;
      sum = held;
    end
    if (slew != 0) begin
      stp = fl16(128'(slew) * dt);
      if (sum < held - stp) sum = held - stp;
      else if (sum > held + stp) sum = held + stp;
    end
    if (sum > 128'(hi_bound)) begin
      sum = 128'(hi_bound); satev[c] = bump(satev[c]); r.sat = 1'b1;
    end
    if (sum < 128'(lo_bound)) begin
      sum = 128'(lo_bound); satev[c] = bump(satev[c]); r.sat = 1'b1;
    end
    held_st[c] = sum[31:0];
    r.command = sum[31:0];
    r.sat_cnt = satev[c]; r.clamp_cnt = clampev[c]; r.fault_cnt = faultev[c];
    return r;
  endfunction

  // send one item, predicting its result at the transfer; valid stays high
  // afterwards so that a following item can go out back to back
  task automatic send_item(input logic [2:0] ch, input logic [31:0] tgt,
      input logic [31:0] meas, input logic [15:0] tstep, input logic clr);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {tstep, meas, tgt};
    s_axis_tuser  <= {clr, ch};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_q.push_back(pid_predict(ch, tgt, meas, tstep, clr));
  endtask

  // wait until every result is back, then let the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_PROP_GAIN:   kp = val;
      REG_INTEG_GAIN:  ki = val;
      REG_DERIV_GAIN:  kd = val;
      REG_INTEG_LIMIT: ilimit = val[30:0];
      REG_OUT_LOW:     lo_bound = val;
      REG_OUT_HIGH:    hi_bound = val;
      REG_DERIV_ALPHA: alpha_reg = val[16:0];
      default:         slew = val[30:0];
    endcase
  endtask

  task automatic write_all(input logic [31:0] p, input logic [31:0] i,
      input logic [31:0] d, input logic [31:0] il, input logic [31:0] lo,
      input logic [31:0] hi, input logic [31:0] a, input logic [31:0] s);
    write_reg(REG_PROP_GAIN, p);   write_reg(REG_INTEG_GAIN, i);
    write_reg(REG_DERIV_GAIN, d);  write_reg(REG_INTEG_LIMIT, il);
    write_reg(REG_OUT_LOW, lo);    write_reg(REG_OUT_HIGH, hi);
    write_reg(REG_DERIV_ALPHA, a); write_reg(REG_SLEW_LIMIT, s);
    cfg_we_i <= 1'b0;
  endtask

  // random angle: mostly moderate, sometimes full range
  function automatic logic [31:0] rand_angle();
    if ($urandom_range(9) < 2) return $urandom();
    return 32'($signed($urandom_range(20000000)) - 10000000);
  endfunction

  function automatic logic [15:0] rand_step();
    case ($urandom_range(5))
      0:       return 16'($urandom_range(40));
      1:       return 16'($urandom());
      default: return 16'($urandom_range(6554, 33));
    endcase
  endfunction

  // directed corner items
  task automatic test_directed();
    send_item(3'd0, 32'h0001_0000, 32'h0, 16'd655, 1'b0);
    send_item(3'd0, 32'h0001_0000, 32'h0, 16'd0, 1'b0);
    send_item(3'd1, 32'h0, 32'h0, 16'hFFFF, 1'b0);
    send_item(3'd6, 32'h1234, 32'h0, 16'd100, 1'b0);   // invalid channel
    send_item(3'd7, 32'hFFFF_FFFF, 32'h0, 16'd100, 1'b0);
    send_item(3'd2, 32'h7FFF_FFFF, 32'h8000_0000, 16'd100, 1'b0); // error overflow
    send_item(3'd2, 32'h8000_0000, 32'h0000_0001, 16'd100, 1'b0);
    send_item(3'd3, 32'h7FFF_FFFF, 32'h0, 16'd6554, 1'b0);        // sum overflow
    send_item(3'd3, 32'h8000_0000, 32'h0, 16'd33, 1'b0);
    send_item(3'd4, 32'h0064_0000, 32'h0, 16'd6554, 1'b0);        // saturates
    send_item(3'd4, 32'hFF9C_0000, 32'h0, 16'd6554, 1'b0);
    send_item(3'd5, 32'h0, 32'h7FFF_FFFF, 16'd32, 1'b0);
    send_item(3'd5, 32'h0, 32'h0, 16'd6555, 1'b0);
    send_item(3'd0, 32'h0, 32'h0, 16'd100, 1'b1);                 // clear
    send_item(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    send_item(3'd0, 32'h0003_0000, 32'h0001_0000, 16'd1000, 1'b0);
    drain();
  endtask

  // register extremes: crossed bounds, full alpha, slew on
  task automatic test_settings();
    write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h0001_0000, 32'hFFFF_0000, 32'h1_FFFF, 32'h7FFF_FFFF);
    for (int i = 0; i < 6; i++)
      send_item(3'(i), rand_angle(), rand_angle(), rand_step(), 1'b0);
    drain();
    write_all(32'h0, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h0, 32'h0000_0001);
    for (int i = 0; i < 6; i++)
      send_item(3'(i), rand_angle(), rand_angle(), rand_step(), 1'b0);
    drain();
  endtask

  // random items under one idling profile and one register setting
  task automatic test_random(input int n, input int idle, input int stall);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    write_all($urandom_range(200000), $urandom_range(20000),
              $urandom_range(2000), $urandom_range(10000000),
              32'($signed($urandom_range(9000000)) - 9000000),
              $urandom_range(9000000), $urandom_range(70000),
              ($urandom_range(1) != 0) ? $urandom_range(5000000) : 0);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(40) == 0)
        send_item(3'($urandom()), $urandom(), $urandom(), 16'($urandom()), 1'b1);
      else if ($urandom_range(15) == 0)
        send_item(3'($urandom_range(7, 6)), rand_angle(), rand_angle(), rand_step(),
                  1'b0);
      else
        send_item(3'($urandom_range(5)), rand_angle(), rand_angle(), rand_step(), 1'b0);
    end
    drain();
  endtask

  // result checker
  always @(posedge clk_i) begin
    pid_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[32], m_axis_tdata[33],
             m_axis_tdata[34], m_axis_tdata[66:35], m_axis_tdata[98:67],
             m_axis_tdata[130:99]};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: %p", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, actual %p", want, got);
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk_i)
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYC) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    mismatches = 0; cycles = 0; send_idle_pct = 0; recv_stall_pct = 0;
    rst_ni = 1'b0; s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = '0;
    m_axis_tready = 1'b1; cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    kp = 65536; ki = 655; kd = 328; ilimit = 31'(1966080); lo_bound = -6553600;
    hi_bound = 6553600; alpha_reg = 17'(16384); slew = '0;
    reset_channels();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_settings();
    test_random(100, 0, 0);
    test_random(90, 85, 0);
    test_random(90, 0, 85);
    test_random(90, 31, 31);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
